### hw/rtl/ppc_pkg.sv
package ppc_pkg;

  // Coordinate width taken from each field (low bits, sign-extended)
  localparam int unsigned CoordW = 32;
  // Differences of two coordinates need one more bit
  localparam int unsigned DiffW = CoordW + 1;
  // Full product of two differences
  localparam int unsigned ProdW = 2 * DiffW;
  // Polygons with fewer vertices than this report outside
  localparam int unsigned MinVertices = 3;
  localparam int unsigned TallyW = $clog2(MinVertices + 1);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic [TallyW-1:0]        tally_t;

  // End points of one edge and the query point
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
  } edge_pts_t;

  // Load strobes for the two register stages of an edge unit
  typedef struct packed {
    logic load_ops;
    logic load_prod;
  } edge_en_t;

  // Per-vertex control that travels down the pipeline
  typedef struct packed {
    logic first;
    logic last;
    logic close_ok;
  } vtx_ctl_t;

endpackage

### hw/rtl/ppc_if.sv
interface ppc_in_if
  import ppc_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t query_x;
  coord_t query_y;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (
    output valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
    output ready
  );
endinterface

interface ppc_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few_vertices;

  modport source (
    output valid, inside_res, too_few_vertices,
    input  ready
  );
  modport sink (
    input  valid, inside_res, too_few_vertices,
    output ready
  );
endinterface

### hw/rtl/point_in_polygon_crossing_core.sv
// Even-odd point-in-polygon test. Vertices stream in one per request; the query
// point is taken with the first vertex of each polygon and ignored on the rest.
// The vertex flagged last closes the polygon and produces exactly one response:
// inside_res by the even-odd rule, or too_few_vertices for fewer than three
// vertices. One vertex is accepted every clock cycle while the input is ready;
// each vertex evaluates the edge to the previous vertex and, on the last vertex,
// the closing edge, each in its own edge unit with two parallel 33x33
// multipliers. After the last vertex is accepted, the product register loads
// and then the response register; a stall can hold either step. An output
// stall reaches the input only when the response register is held, the product
// stage holds the next last vertex and the operand stage is occupied.
module point_in_polygon_crossing_core
  import ppc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ppc_in_if.sink        in_i,
  ppc_out_if.source     out_o
);

  tally_t   tally_q, tally_d;
  coord_t   held_x_q, held_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  coord_t   vx, vy;
  logic     in_acc, is_first;
  vtx_ctl_t ctl_in;

  logic     s1_v_q, s2_v_q, out_v_q;
  vtx_ctl_t s1_ctl_q, s2_ctl_q;
  logic     s1_ready, s2_ready, s3_ok, s2_take, out_free;
  logic     parity_q, parity_d, parity_new;
  logic     inside_q, too_few_q;
  logic     cross_step, cross_close;
  edge_en_t edge_en;
  edge_pts_t step_pts, close_pts;

  assign vx       = coord_t'(in_i.vertex_x[CoordW-1:0]);
  assign vy       = coord_t'(in_i.vertex_y[CoordW-1:0]);
  assign in_acc   = in_i.valid && in_i.ready;
  assign is_first = (tally_q == '0);

  // Per-vertex control decided at accept
  assign ctl_in.first    = is_first;
  assign ctl_in.last     = in_i.last_vertex;
  assign ctl_in.close_ok = in_i.last_vertex && (tally_q >= tally_t'(MinVertices - 1));

  // Advance the vertex tally, saturate, restart after the last vertex
  always_comb begin
    if (in_i.last_vertex) begin
      tally_d = '0;
    end else if (tally_q < tally_t'(MinVertices)) begin
      tally_d = tally_q + tally_t'(1);
    end else begin
      tally_d = tally_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (in_acc) begin
      tally_q <= tally_d;
    end
  end

  // Hold the point, the first vertex and the previous vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q  <= '0;
      held_y_q  <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (in_acc) begin
      if (is_first) begin
        held_x_q  <= coord_t'(in_i.query_x[CoordW-1:0]);
        held_y_q  <= coord_t'(in_i.query_y[CoordW-1:0]);
        first_x_q <= vx;
        first_y_q <= vy;
      end
      prev_x_q <= vx;
      prev_y_q <= vy;
    end
  end

  // Edge from the previous vertex, and the closing edge to the first
  assign step_pts  = '{cx: vx, cy: vy, bx: prev_x_q, by: prev_y_q,
                       px: held_x_q, py: held_y_q};
  assign close_pts = '{cx: first_x_q, cy: first_y_q, bx: vx, by: vy,
                       px: held_x_q, py: held_y_q};

  assign edge_en.load_ops  = in_acc;
  assign edge_en.load_prod = s1_v_q && s2_ready;

  ppc_edge u_edge_step (
    .clk_i   (clk_i),
    .en_i    (edge_en),
    .pts_i   (step_pts),
    .cross_o (cross_step)
  );

  ppc_edge u_edge_close (
    .clk_i   (clk_i),
    .en_i    (edge_en),
    .pts_i   (close_pts),
    .cross_o (cross_close)
  );

  // Stage flow control; only a last vertex needs the response register
  assign out_free = !out_v_q || out_o.ready;
  assign s3_ok    = !s2_ctl_q.last || out_free;
  assign s2_take  = s2_v_q && s3_ok;
  assign s2_ready = !s2_v_q || s3_ok;
  assign s1_ready = !s1_v_q || s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s2_ready) begin
        s1_v_q <= 1'b0;
      end
      if (edge_en.load_prod) begin
        s2_v_q <= 1'b1;
      end else if (s2_take) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctl_q <= ctl_in;
    end
    if (edge_en.load_prod) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  // Toggle parity on each crossing; clear it once a polygon closes
  always_comb begin
    parity_new = s2_ctl_q.first ? 1'b0 : (parity_q ^ cross_step);
    if (s2_ctl_q.close_ok) begin
      parity_new = parity_new ^ cross_close;
    end
    parity_d = parity_q;
    if (s2_take) begin
      parity_d = s2_ctl_q.last ? 1'b0 : parity_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
    end else begin
      parity_q <= parity_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_take && s2_ctl_q.last) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take && s2_ctl_q.last) begin
      inside_q  <= s2_ctl_q.close_ok && parity_new;
      too_few_q <= !s2_ctl_q.close_ok;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.inside_res       = inside_q;
  assign out_o.too_few_vertices = too_few_q;

endmodule

### hw/rtl/ppc_edge.sv
module ppc_edge
  import ppc_pkg::*;
(
  input  logic      clk_i,
  input  edge_en_t  en_i,
  input  edge_pts_t pts_i,
  output logic      cross_o
);

  logic  strad_q, strad2_q;
  diff_t lx_q, dy_q, ry_q, rx_q;
  prod_t lprod_q, rprod_q;
  logic  dyneg_q;

  // Capture differences and the straddle test
  always_ff @(posedge clk_i) begin
    if (en_i.load_ops) begin
      strad_q <= (pts_i.cy > pts_i.py) != (pts_i.by > pts_i.py);
      lx_q    <= diff_t'(pts_i.px) - diff_t'(pts_i.cx);
      dy_q    <= diff_t'(pts_i.by) - diff_t'(pts_i.cy);
      ry_q    <= diff_t'(pts_i.py) - diff_t'(pts_i.cy);
      rx_q    <= diff_t'(pts_i.bx) - diff_t'(pts_i.cx);
    end
  end

  // Cross-multiply instead of dividing out the crossing abscissa
  always_ff @(posedge clk_i) begin
    if (en_i.load_prod) begin
      strad2_q <= strad_q;
      dyneg_q  <= dy_q[DiffW-1];
      lprod_q  <= prod_t'(lx_q) * prod_t'(dy_q);
      rprod_q  <= prod_t'(ry_q) * prod_t'(rx_q);
    end
  end

  // Flip the compare sense for a downward edge
  assign cross_o = strad2_q && (dyneg_q ? (lprod_q > rprod_q) : (lprod_q < rprod_q));

endmodule

### hw/rtl/ppc_checker.sv
module ppc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_inside_i,
  input logic out_too_few_i
);

  logic       last_acc, out_acc;
  logic [2:0] pending_q;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;

  // Count closed polygons whose response is still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b00, last_acc} - {2'b00, out_acc};
    end
  end

  // A stalled response keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_inside_i)
      && $stable(out_too_few_i))
    else $error("response changed while stalled");

  // No response without a closed polygon behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 3'd0)
    else $error("response without a last vertex");

  // At most three polygons in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("too many responses owed");

  // An empty response register never blocks requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request blocked with free response register");

endmodule

bind point_in_polygon_crossing_core ppc_checker u_ppc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last_vertex),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_inside_i  (out_o.inside_res),
  .out_too_few_i (out_o.too_few_vertices)
);

### sim/ppc_scoreboard_pkg.sv
`timescale 1ns / 100ps

package ppc_scoreboard_pkg;
  import ppc_pkg::*;

  // One vertex request as seen on the input channel
  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } vertex_req_t;

  // One polygon verdict as seen on the output channel
  typedef struct packed {
    logic inside_res;
    logic too_few_vertices;
  } verdict_t;

  // Wide enough for the exact product of two coordinate differences
  typedef logic signed [CoordW*2+3:0] wide_t;

  class polygon_scoreboard;
    coord_t      held_x, held_y;
    coord_t      first_x, first_y;
    coord_t      prev_x, prev_y;
    bit          parity;
    tally_t      tally;
    verdict_t    verdict_q[$];
    int unsigned mismatches;

    function new();
      held_x = '0;
      held_y = '0;
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      parity = 1'b0;
      tally = '0;
      mismatches = 0;
    endfunction

    // Edge from (cx, cy) to (bx, by) against the +x ray from the held point
    function bit crosses_ray(coord_t cx, coord_t cy, coord_t bx, coord_t by);
      wide_t span_y, lhs, rhs;
      if ((cy > held_y) == (by > held_y)) return 1'b0;
      span_y = wide_t'(by) - wide_t'(cy);
      lhs = (wide_t'(held_x) - wide_t'(cx)) * span_y;
      rhs = (wide_t'(held_y) - wide_t'(cy)) * (wide_t'(bx) - wide_t'(cx));
      // Dividing by a negative span flips the sense of the compare
      return (span_y < 0) ? (rhs < lhs) : (lhs < rhs);
    endfunction

    // Advance the polygon state by one accepted vertex request
    function void note_vertex(vertex_req_t v);
      verdict_t verdict;
      if (tally == '0) begin
        held_x = v.query_x;
        held_y = v.query_y;
        first_x = v.vertex_x;
        first_y = v.vertex_y;
        parity = 1'b0;
        tally = tally_t'(1);
      end else begin
        if (crosses_ray(v.vertex_x, v.vertex_y, prev_x, prev_y)) parity = !parity;
        if (tally < tally_t'(MinVertices)) tally = tally + tally_t'(1);
      end
      prev_x = v.vertex_x;
      prev_y = v.vertex_y;
      if (!v.last_vertex) return;

      // Close the polygon and produce its verdict
      if (tally >= tally_t'(MinVertices)) begin
        if (crosses_ray(first_x, first_y, v.vertex_x, v.vertex_y)) parity = !parity;
        verdict.inside_res = parity;
        verdict.too_few_vertices = 1'b0;
      end else begin
        verdict.inside_res = 1'b0;
        verdict.too_few_vertices = 1'b1;
      end
      verdict_q = {verdict_q, verdict};
      parity = 1'b0;
      tally = '0;
    endfunction

    // Compare one accepted response with the oldest outstanding verdict
    function void check_response(logic inside_res, logic too_few_vertices);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("response with no polygon outstanding: inside_res=%b too_few_vertices=%b",
               inside_res, too_few_vertices);
        mismatches++;
        return;
      end
      want = verdict_q.pop_front();
      if (inside_res !== want.inside_res) begin
        $error("inside_res: expected %b, got %b", want.inside_res, inside_res);
        mismatches++;
      end
      if (too_few_vertices !== want.too_few_vertices) begin
        $error("too_few_vertices: expected %b, got %b", want.too_few_vertices,
               too_few_vertices);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

endpackage

### sim/point_in_polygon_crossing_core_test.sv
`timescale 1ns / 100ps

module point_in_polygon_crossing_core_test;
  import ppc_pkg::*;
  import ppc_scoreboard_pkg::*;

  localparam int unsigned VertexTarget  = 1200;
  localparam int unsigned HoldOffCycles = 300;
  localparam coord_t One     = 32'sh0001_0000;
  localparam coord_t MostNeg = 32'sh8000_0000;
  localparam coord_t MostPos = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  bit   hold_off_req;
  int unsigned sent_vertices;

  polygon_scoreboard board = new();

  ppc_in_if  in_bus ();
  ppc_out_if out_bus ();

  point_in_polygon_crossing_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Note every accepted vertex request
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      board.note_vertex('{in_bus.query_x, in_bus.query_y, in_bus.vertex_x,
                          in_bus.vertex_y, in_bus.last_vertex});
    end
  end

  // Check every accepted response
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      board.check_response(out_bus.inside_res, out_bus.too_few_vertices);
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, idle-free stretches, and one long hold-off on request
  initial begin
    int run;
    int gap;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_bus.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Offer one vertex request and hold it until accepted
  task automatic send_vertex(vertex_req_t v, bit eager);
    int gap;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.query_x     <= v.query_x;
    in_bus.query_y     <= v.query_y;
    in_bus.vertex_x    <= v.vertex_x;
    in_bus.vertex_y    <= v.vertex_y;
    in_bus.last_vertex <= v.last_vertex;
    do @(posedge clk); while (!in_bus.ready);
    sent_vertices++;
  endtask

  // Stream a whole polygon; query fields past the first vertex are junk
  task automatic send_polygon(coord_t qx, coord_t qy, coord_t xs[$], coord_t ys[$],
                              bit eager);
    vertex_req_t v;
    for (int i = 0; i < xs.size(); i++) begin
      v.query_x     = (i == 0) ? qx : coord_t'($urandom);
      v.query_y     = (i == 0) ? qy : coord_t'($urandom);
      v.vertex_x    = xs[i];
      v.vertex_y    = ys[i];
      v.last_vertex = (i == xs.size() - 1);
      send_vertex(v, eager);
    end
  endtask

  // Coordinate on a coarse grid around a base, so ties with the query are common
  function automatic coord_t near_coord(coord_t base, int shift);
    return coord_t'(base + ((int'($urandom_range(0, 8)) - 4) <<< shift));
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 5))
      0: return MostNeg;
      1: return MostPos;
      2: return '0;
      3: return -coord_t'(1);
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Random polygon: mostly small and clustered around the query point
  task automatic send_random_polygon(bit eager, bit tiny);
    coord_t qx, qy;
    coord_t xs[$], ys[$];
    int unsigned r;
    int unsigned n;
    int unsigned style;
    int shift;
    r = $urandom_range(0, 99);
    if (tiny) n = $urandom_range(1, 3);
    else if (r < 8) n = $urandom_range(1, 2);
    else if (r < 90) n = $urandom_range(3, 8);
    else n = $urandom_range(9, 24);
    style = $urandom_range(0, 99);
    shift = $urandom_range(0, 30);
    qx = ($urandom_range(0, 3) == 0) ? edge_coord() : coord_t'($urandom);
    qy = ($urandom_range(0, 3) == 0) ? edge_coord() : coord_t'($urandom);
    for (int i = 0; i < n; i++) begin
      if (style < 65) begin
        xs = {xs, near_coord(qx, shift)};
        ys = {ys, near_coord(qy, shift)};
      end else if (style < 80) begin
        xs = {xs, coord_t'($urandom)};
        ys = {ys, coord_t'($urandom)};
      end else begin
        xs = {xs, edge_coord()};
        ys = {ys, edge_coord()};
      end
    end
    send_polygon(qx, qy, xs, ys, eager);
  endtask

  // Stimulus and end of run
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.query_x     = '0;
    in_bus.query_y     = '0;
    in_bus.vertex_x    = '0;
    in_bus.vertex_y    = '0;
    in_bus.last_vertex = 1'b0;
    hold_off_req       = 1'b0;
    sent_vertices      = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single vertex, then two vertices: both too few
    send_polygon(One, One, '{One}, '{-One}, 1'b0);
    send_polygon('0, '0, '{-One, One}, '{-One, One}, 1'b0);
    // Square from -One to One with the point inside, then outside
    send_polygon('0, '0, '{-One, One, One, -One}, '{-One, -One, One, One}, 1'b0);
    send_polygon(3 * One, '0, '{-One, One, One, -One}, '{-One, -One, One, One}, 1'b1);
    // Vertex exactly on the ray's ordinate
    send_polygon('0, '0, '{-One, 2 * One, -One}, '{-One, '0, One}, 1'b0);
    // Point on the right edge and on the bottom edge
    send_polygon(One, '0, '{-One, One, One, -One}, '{-One, -One, One, One}, 1'b1);
    send_polygon('0, -One, '{-One, One, One, -One}, '{-One, -One, One, One}, 1'b0);
    // Full-scale triangle, point at the center and on a corner
    send_polygon('0, '0, '{MostNeg, MostPos, '0}, '{MostNeg, MostNeg, MostPos}, 1'b0);
    send_polygon(MostNeg, MostNeg, '{MostNeg, MostPos, '0}, '{MostNeg, MostNeg, MostPos},
                 1'b1);

    // Random polygons
    while (sent_vertices < VertexTarget / 2) send_random_polygon($urandom_range(0, 3) == 0,
                                                                 1'b0);

    // Hold off the receiver while short polygons keep arriving back to back
    hold_off_req = 1'b1;
    repeat (40) send_random_polygon(1'b1, 1'b1);

    while (sent_vertices < VertexTarget) send_random_polygon($urandom_range(0, 3) == 0,
                                                             1'b0);
    in_bus.valid <= 1'b0;

    // Drain outstanding verdicts, then let the pipeline settle
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_if.sv
hw/rtl/ppc_edge.sv
hw/rtl/point_in_polygon_crossing_core.sv
hw/rtl/ppc_checker.sv
sim/ppc_scoreboard_pkg.sv
sim/point_in_polygon_crossing_core_test.sv
